FILE: hdl/spq_pkg.sv
package spq_pkg;

    localparam int KEY_WIDTH     = 16;
    localparam int STATUS_WIDTH  = 2;
    localparam int COUNT_WIDTH   = 4;
    localparam int CAPACITY_DEF  = 8;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0]
    {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Update enables broadcast to every cell of the chain.
    typedef struct packed
    {
        logic ins;
        logic rem;
    } spq_ctrl_t;

    // What one cell shows to its neighbors and to the control logic.
    typedef struct packed
    {
        logic                 vld;
        logic [KEY_WIDTH-1:0] data;
        logic                 ge;
        logic                 eq;
    } spq_link_t;

endpackage

FILE: hdl/spq_if.sv
interface spq_req_if;
    import spq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [KEY_WIDTH-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  count;
    logic [KEY_WIDTH-1:0]    head_key;

    modport source (output valid, output status, output count, output head_key, input ready);
    modport sink   (input valid, input status, input count, input head_key, output ready);
endinterface

FILE: hdl/spq_cell.sv
module spq_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::spq_ctrl_t            ctrl,
    input  logic [spq_pkg::KEY_WIDTH-1:0] key,
    input  spq_pkg::spq_link_t            prev,
    input  spq_pkg::spq_link_t            next,
    output spq_pkg::spq_link_t            link
);
    import spq_pkg::*;

    logic                 vld_reg;
    logic                 vld_next;
    logic [KEY_WIDTH-1:0] data_reg;
    logic [KEY_WIDTH-1:0] data_next;
    logic                 ge;

    // An empty cell counts as holding a key below every possible key.
    assign ge = !vld_reg || (key >= data_reg);

    always_comb
    begin
        vld_next  = vld_reg;
        data_next = data_reg;
        if (ctrl.ins)
        begin
            vld_next = vld_reg | prev.vld;
            if (prev.ge)
            begin
                data_next = prev.data;
            end
            else if (ge)
            begin
                data_next = key;
            end
        end
        else if (ctrl.rem)
        begin
            vld_next = next.vld;
            if (ge)
            begin
                data_next = next.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.vld  = vld_reg;
    assign link.data = data_reg;
    assign link.ge   = ge;
    assign link.eq   = vld_reg && (key == data_reg);

endmodule

FILE: hdl/sorted_priority_queue_core.sv
// Sorted priority queue holding up to CAPACITY keys, largest first.
// Requests arrive on req (op, key) and each request gives exactly one
// transfer on rsp (status, count, head_key). An insert places the key in
// front of the first stored key less than or equal to it; a remove deletes
// the first stored key equal to it. Status reports a full queue on insert,
// an empty queue or a missing key on remove, and then nothing changes.
// The keys sit in a row of cells. Each cell compares its key with the
// request and loads from its left or right neighbor, so the whole update
// is done in the cycle the request is taken. The response is registered and
// appears in the cycle after the request transfer, and a new request is taken
// every cycle while rsp is ready, so throughput is one request per cycle.
// A response waiting on a stalled receiver sits in the output register;
// req.ready is held low until it is taken, and the queue does not change.
// Reset empties the queue at once and drops any pending response.
module sorted_priority_queue_core
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_link_t             link [CAPACITY];
    spq_ctrl_t             ctrl;
    logic [CAPACITY-1:0]   vld_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  found;
    status_t               status;
    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic [KEY_WIDTH-1:0]  head_next;
    logic [CNT_W+COUNT_WIDTH-1:0] occ_wide;

    logic                    rsp_valid_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [KEY_WIDTH-1:0]    head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            spq_link_t prev_l;
            spq_link_t next_l;

            if (gi == 0)
            begin : g_first
                assign prev_l = '{vld: 1'b1, data: '0, ge: 1'b0, eq: 1'b0};
            end
            else
            begin : g_mid
                assign prev_l = link[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_l = '{vld: 1'b0, data: '0, ge: 1'b0, eq: 1'b0};
            end
            else
            begin : g_body
                assign next_l = link[gi+1];
            end

            spq_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .key   (req.key),
                .prev  (prev_l),
                .next  (next_l),
                .link  (link[gi])
            );

            assign vld_vec[gi] = link[gi].vld;
            assign eq_vec[gi]  = link[gi].eq;
        end
    endgenerate

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign full  = link[CAPACITY-1].vld;
    assign empty = !link[0].vld;
    assign found = |eq_vec;

    always_comb
    begin
        ctrl     = '{ins: 1'b0, rem: 1'b0};
        status   = ST_OK;
        occ_next = occ_reg;
        if (req.op == OP_INSERT)
        begin
            if (full)
            begin
                status = ST_FULL;
            end
            else
            begin
                ctrl.ins = accept;
                occ_next = occ_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status = ST_EMPTY;
            end
            else if (!found)
            begin
                status = ST_NOT_FOUND;
            end
            else
            begin
                ctrl.rem = accept;
                occ_next = occ_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        head_next = empty ? '0 : link[0].data;
        if (status == ST_OK)
        begin
            if (req.op == OP_INSERT)
            begin
                head_next = link[0].ge ? req.key : link[0].data;
            end
            else if (occ_next == '0)
            begin
                head_next = '0;
            end
            else if (link[0].eq)
            begin
                head_next = link[1].data;
            end
        end
    end

    assign occ_wide = {{COUNT_WIDTH{1'b0}}, occ_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg <= occ_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            count_reg  <= occ_wide[COUNT_WIDTH-1:0];
            head_reg   <= head_next;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.count    = count_reg;
    assign rsp.head_key = head_reg;

    logic [CAPACITY:0]             thermo;
    logic                          sorted_ok;
    logic [CNT_W+COUNT_WIDTH-1:0]  occ_reg_wide;

    assign thermo       = ({{CAPACITY{1'b0}}, 1'b1} << occ_reg) - 1'b1;
    assign occ_reg_wide = {{COUNT_WIDTH{1'b0}}, occ_reg};

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (link[i].vld && (link[i].data > link[i-1].data))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    // The valid cells always form a prefix whose length is the occupancy.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        vld_vec == thermo[CAPACITY-1:0])
        else $error("valid cells do not match occupancy");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("stored keys are not in descending order");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (count_reg == occ_reg_wide[COUNT_WIDTH-1:0]))
        else $error("reported count differs from occupancy");

    a_rsp_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (head_reg == (link[0].vld ? link[0].data : '0)))
        else $error("reported head differs from first cell");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status != ST_OK)) |=> (vld_vec == $past(vld_vec)))
        else $error("rejected request changed the queue");

endmodule

FILE: test/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if          req,
    spq_rsp_if          rsp,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    typedef struct packed
    {
        status_t                status;
        logic [COUNT_WIDTH-1:0] count;
        logic [KEY_WIDTH-1:0]   head_key;
    } queue_result_t;

    queue_result_t        awaited_results[$];
    logic [KEY_WIDTH-1:0] slots [CAPACITY];
    int unsigned          used;
    int unsigned          rsp_index;

    task automatic report_failure(input string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    // Slots below used are kept in descending order, largest at slot 0.
    task automatic apply_request(input op_t op, input logic [KEY_WIDTH-1:0] key,
                                 output queue_result_t res);
        int pos;
        int j;
        res.status = ST_OK;
        if (op == OP_INSERT)
        begin
            if (used >= CAPACITY)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < used && key < slots[pos])
                    pos++;
                for (j = used; j > pos; j--)
                    slots[j] = slots[j-1];
                slots[pos] = key;
                used++;
            end
        end
        else
        begin
            if (used == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                pos = 0;
                while (pos < used && slots[pos] != key)
                    pos++;
                if (pos >= used)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (j = pos; j + 1 < used; j++)
                        slots[j] = slots[j+1];
                    used--;
                end
            end
        end
        res.count    = COUNT_WIDTH'(used);
        res.head_key = (used > 0) ? slots[0] : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t predicted;
        queue_result_t oldest;
        if (!rst_n)
        begin
            awaited_results.delete();
            used        = 0;
            rsp_index   = 0;
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                apply_request(op_t'(req.op), req.key, predicted);
                awaited_results.push_back(predicted);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_failure($sformatf("response %0d arrived with none awaited",
                                             rsp_index));
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (rsp.status !== oldest.status)
                        report_failure($sformatf("response %0d: status %0d, expected %0d",
                                                 rsp_index, rsp.status, oldest.status));
                    if (rsp.count !== oldest.count)
                        report_failure($sformatf("response %0d: count %0d, expected %0d",
                                                 rsp_index, rsp.count, oldest.count));
                    if (rsp.head_key !== oldest.head_key)
                        report_failure($sformatf("response %0d: head_key %0h, expected %0h",
                                                 rsp_index, rsp.head_key, oldest.head_key));
                end
                rsp_index++;
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

FILE: test/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = CAPACITY_DEF;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned long_stall;
    bit          rx_idle_on;
    bit          filling;

    logic [KEY_WIDTH-1:0] live_keys[$];

    spq_req_if req_ch();
    spq_rsp_if rsp_ch();

    sorted_priority_queue_core i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    spq_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return KEY_WIDTH'($urandom_range(0, 7));
        if (r < 5)
            return KEY_WIDTH'(16'hFFFF - $urandom_range(0, 7));
        if (r < 6)
            return KEY_WIDTH'(16'h8000 + $urandom_range(0, 3));
        return KEY_WIDTH'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                long_stall--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!rx_idle_on)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic issue(input op_t op, input logic [KEY_WIDTH-1:0] key, input int gap);
        int i;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (op == OP_INSERT)
        begin
            if (live_keys.size() < QUEUE_DEPTH)
                live_keys.push_back(key);
        end
        else
        begin
            for (i = 0; i < live_keys.size(); i++)
            begin
                if (live_keys[i] == key)
                begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Alternates between filling and draining so the queue swings between empty and full.
    task automatic next_item(output op_t op, output logic [KEY_WIDTH-1:0] key);
        int ins_pct;
        if (live_keys.size() >= QUEUE_DEPTH)
            filling = 1'b0;
        else if (live_keys.size() == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 29) == 0)
            filling = !filling;
        ins_pct = filling ? 75 : 25;
        if ($urandom_range(0, 99) < ins_pct)
        begin
            op  = OP_INSERT;
            key = pick_key();
        end
        else
        begin
            op = OP_REMOVE;
            if (live_keys.size() > 0 && $urandom_range(0, 4) != 0)
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else
                key = pick_key();
        end
    endtask

    task automatic run_random(input int n_items, input bit tx_idle);
        op_t                  op;
        logic [KEY_WIDTH-1:0] key;
        repeat (n_items)
        begin
            next_item(op, key);
            issue(op, key, tx_idle ? pick_gap() : 0);
        end
        wait_drained();
    endtask

    task automatic flood(input int n_items, input int hold);
        op_t                  op;
        logic [KEY_WIDTH-1:0] key;
        long_stall = hold;
        repeat (n_items)
        begin
            next_item(op, key);
            issue(op, key, 0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        long_stall   = 0;
        rx_idle_on   = 1'b0;
        filling      = 1'b1;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_INSERT;
        req_ch.key   <= '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(OP_REMOVE, 16'h0000, 0);
        issue(OP_INSERT, 16'h0000, 0);
        issue(OP_INSERT, 16'hFFFF, 0);
        issue(OP_INSERT, 16'h8000, 0);
        issue(OP_INSERT, 16'h8000, 0);
        issue(OP_INSERT, 16'h5555, 0);
        issue(OP_INSERT, 16'hAAAA, 0);
        issue(OP_INSERT, 16'h0001, 0);
        issue(OP_INSERT, 16'hFFFE, 0);
        issue(OP_INSERT, 16'h1234, 0);
        issue(OP_INSERT, 16'hFFFF, 0);
        issue(OP_REMOVE, 16'h4321, 0);
        issue(OP_REMOVE, 16'h8000, 0);
        issue(OP_REMOVE, 16'hFFFF, 0);
        issue(OP_REMOVE, 16'h0000, 0);
        issue(OP_REMOVE, 16'h8000, 0);
        issue(OP_REMOVE, 16'h5555, 0);
        issue(OP_REMOVE, 16'hAAAA, 0);
        issue(OP_REMOVE, 16'h0001, 0);
        issue(OP_REMOVE, 16'hFFFE, 0);
        issue(OP_REMOVE, 16'hFFFE, 0);
        issue(OP_INSERT, 16'h0000, 0);
        wait_drained();

        run_random(150, 1'b0);
        flood(24, 80);

        rx_idle_on = 1'b1;
        run_random(250, 1'b1);

        rx_idle_on = 1'b0;
        run_random(150, 1'b1);

        rx_idle_on = 1'b1;
        run_random(150, 1'b0);
        flood(12, 40);

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
test/spq_checker.sv
test/tb_sorted_priority_queue_core.sv
